FILE: design/bcd_clk_pkg.sv
// Shared types, codes and helpers for the BCD 12/24-hour clock.
`default_nettype none
package bcd_clk_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ADJUST = 2'd1,
        FUNC_FORMAT = 2'd2,
        FUNC_EDIT   = 2'd3
    } t_func;

    localparam logic [2:0] DIG_HT = 3'd0;
    localparam logic [2:0] DIG_HO = 3'd1;
    localparam logic [2:0] DIG_MT = 3'd2;
    localparam logic [2:0] DIG_MO = 3'd3;
    localparam logic [2:0] DIG_ST = 3'd4;
    localparam logic [2:0] DIG_SO = 3'd5;

    typedef struct packed {
        t_func      func;
        logic [2:0] digit_select;
        logic       step_down;
    } t_in_item;

    // The result item shows the whole clock state, so it doubles as the state type.
    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       twelve_hour_mode;
        logic       is_morning;
        logic       edit_active;
    } t_out_item;

    localparam t_out_item STATE_RESET = '{
        hour_tens: 2'd0, hour_ones: 4'd0, minute_tens: 3'd0, minute_ones: 4'd0,
        second_tens: 3'd0, second_ones: 4'd0, twelve_hour_mode: 1'b0,
        is_morning: 1'b1, edit_active: 1'b0
    };

    // +1 or -1 on one digit, clamped at zero going down.
    function automatic logic [3:0] adj_digit(input logic [3:0] d, input logic down);
        logic [3:0] r;
        if (down) begin
            r = (d != 4'd0) ? d - 4'd1 : d;
        end else begin
            r = d + 4'd1;
        end
        return r;
    endfunction

    // Split an hour value below 30 into {tens, ones}.
    function automatic logic [5:0] split_hours(input logic [5:0] h);
        logic [5:0] r;
        if (h >= 6'd20) begin
            r = {2'd2, 4'(h - 6'd20)};
        end else if (h >= 6'd10) begin
            r = {2'd1, 4'(h - 6'd10)};
        end else begin
            r = {2'd0, h[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/bcd_clk_update.sv
// Next-state logic of the clock: tick, digit adjust, format change, edit hold.
`default_nettype none
module bcd_clk_update (
    input  wire bcd_clk_pkg::t_out_item i_state,
    input  wire bcd_clk_pkg::t_in_item  i_item,
    output bcd_clk_pkg::t_out_item      o_state
);
    import bcd_clk_pkg::*;

    always_comb begin
        logic [3:0] ht, ho, mt, mo, st, so;
        logic       twelve, morn, edit, run_chain;
        logic [5:0] h, hs;

        ht        = {2'b00, i_state.hour_tens};
        ho        = i_state.hour_ones;
        mt        = {1'b0, i_state.minute_tens};
        mo        = i_state.minute_ones;
        st        = {1'b0, i_state.second_tens};
        so        = i_state.second_ones;
        twelve    = i_state.twelve_hour_mode;
        morn      = i_state.is_morning;
        edit      = i_state.edit_active;
        run_chain = 1'b0;
        h         = 6'(ht) * 6'd10 + 6'(ho);
        hs        = 6'd0;

        case (i_item.func)
            FUNC_TICK: begin
                if (!edit) begin
                    so        = so + 4'd1;
                    run_chain = 1'b1;
                end
            end
            FUNC_ADJUST: begin
                run_chain = 1'b1;
                case (i_item.digit_select)
                    DIG_HT:  ht = adj_digit(ht, i_item.step_down);
                    DIG_HO:  ho = adj_digit(ho, i_item.step_down);
                    DIG_MT:  mt = adj_digit(mt, i_item.step_down);
                    DIG_MO:  mo = adj_digit(mo, i_item.step_down);
                    DIG_ST:  st = adj_digit(st, i_item.step_down);
                    DIG_SO:  so = adj_digit(so, i_item.step_down);
                    default: ;
                endcase
            end
            FUNC_FORMAT: begin
                if (!edit) begin
                    twelve = !twelve;
                    if (twelve) begin
                        if (h < 6'd13) begin
                            morn = 1'b1;
                        end else begin
                            hs   = split_hours(h - 6'd12);
                            ht   = {2'b00, hs[5:4]};
                            ho   = hs[3:0];
                            morn = 1'b0;
                        end
                    end else if (!morn) begin
                        h  = h + 6'd12;
                        if (h >= 6'd24) begin
                            h = h - 6'd24;
                        end
                        hs = split_hours(h);
                        ht = {2'b00, hs[5:4]};
                        ho = hs[3:0];
                    end
                end
            end
            FUNC_EDIT: begin
                edit = !edit;
            end
            default: ;
        endcase

        if (run_chain) begin
            if (so == 4'd10) begin so = 4'd0; st = st + 4'd1; end
            if (st == 4'd6)  begin st = 4'd0; mo = mo + 4'd1; end
            if (mo == 4'd10) begin mo = 4'd0; mt = mt + 4'd1; end
            if (mt == 4'd6)  begin mt = 4'd0; ho = ho + 4'd1; end
            if (ho == 4'd10) begin ho = 4'd0; ht = ht + 4'd1; end
            if (twelve) begin
                // 13 o'clock rolls to 1 and flips AM/PM; other overflow just snaps to 1
                if (ht == 4'd1 && ho == 4'd3) begin
                    ht   = 4'd0;
                    ho   = 4'd1;
                    morn = !morn;
                end else if (ht > 4'd1) begin
                    ht = 4'd0;
                    ho = 4'd1;
                end
            end else if ((ht == 4'd2 && ho == 4'd4) || ht > 4'd2) begin
                ht = 4'd0;
                ho = 4'd0;
            end
        end

        o_state.hour_tens        = ht[1:0];
        o_state.hour_ones        = ho;
        o_state.minute_tens      = mt[2:0];
        o_state.minute_ones      = mo;
        o_state.second_tens      = st[2:0];
        o_state.second_ones      = so;
        o_state.twelve_hour_mode = twelve;
        o_state.is_morning       = morn;
        o_state.edit_active      = edit;
    end

endmodule
`default_nettype wire

FILE: design/bcd_clock_12_24_with_edit.sv
// BCD HH:MM:SS clock with 12/24-hour format, AM/PM flag and edit hold.
// Input channel: i_in_valid / o_in_ready carry one event item (tick, digit
// adjust, format toggle, edit toggle). Output channel: o_out_valid /
// i_out_ready carry one result item per event, showing the full clock state
// after that event.
// An accepted item is first registered in the input register; its result
// is then registered in the result register, from which it can be taken
// (input register then result register).
// Throughput: one item per cycle while the receiver takes each result; the
// combinational digit update between input and state registers sets this.
// The clock state itself is the result register: it only moves when the
// previous result has been taken or is being taken.
// Reset (synchronous, active low): 00:00:00, 24-hour mode, AM, edit hold off,
// both pipeline registers empty.
// When the receiver stalls, the result holds, the input register fills, and
// o_in_ready drops until the result is taken.
`default_nettype none
module bcd_clock_12_24_with_edit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire bcd_clk_pkg::t_in_item  i_in_item,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output bcd_clk_pkg::t_out_item      o_out_item
);
    import bcd_clk_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_state;
    t_out_item n_state;
    logic      advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bcd_clk_update u_update (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_state;

    // Digits stay in BCD range.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.second_ones <= 4'd9 && r_state.second_tens <= 3'd5 &&
        r_state.minute_ones <= 4'd9 && r_state.minute_tens <= 3'd5 &&
        r_state.hour_ones <= 4'd9 && r_state.hour_tens <= 2'd2)
        else $error("clock digit out of range");

    // In 12-hour form the hour tens never reaches 2.
    a_twelve_hours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.twelve_hour_mode |-> r_state.hour_tens <= 2'd1)
        else $error("hour tens too large in 12-hour mode");

    // An edit toggle always flips the hold.
    a_edit_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_EDIT |=>
        r_state.edit_active != $past(r_state.edit_active))
        else $error("edit toggle did not flip hold");

    // State only changes when an item passes through the update stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("clock state changed without an item");

endmodule
`default_nettype wire
